/* hdl/sbfd_pkg.sv */
// Shared types and constants for the spectrum bar falloff drawer.
package sbfd_pkg;

   // Field widths.
   localparam int CNT_W    = 9;
   localparam int PIX_W    = 12;
   localparam int STEP_W   = 8;
   localparam int COLOR_W  = 16;
   localparam int VALUE_W  = 32;
   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Largest number of bars the height store holds.
   localparam int MAX_BARS_DEF = 256;

   // Register indexes on the control port.
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_STEP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR      = 3'd5;

   // Register values after reset.
   localparam logic [CNT_W-1:0]   BAR_COUNT_RST     = 9'd32;
   localparam logic [PIX_W-1:0]   SCREEN_WIDTH_RST  = 12'd320;
   localparam logic [PIX_W-1:0]   SCREEN_HEIGHT_RST = 12'd240;
   localparam logic [STEP_W-1:0]  FALL_INTERVAL_RST = 8'd50;
   localparam logic [STEP_W-1:0]  FALL_STEP_RST     = 8'd4;
   localparam logic [COLOR_W-1:0] BG_COLOR_RST      = 16'd0;
   localparam logic [PIX_W-1:0]   BAR_WIDTH_RST     = PIX_W'(320 / 32);

   // RGB565 blue used for painted bars.
   localparam logic [COLOR_W-1:0] PAINT_COLOR = 16'h001F;

   // Item modes.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_BAR  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [VALUE_W-1:0] bar_value;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   rect_x;
      logic [PIX_W-1:0]   rect_y;
      logic [PIX_W-1:0]   rect_w;
      logic [PIX_W-1:0]   rect_h;
      logic [COLOR_W-1:0] fill_color;
      logic               is_erase;
   } rsp_type;

endpackage

/* hdl/spectrum_bar_falloff_drawer_unit.sv */
// Spectrum bar graph drawer with peak falloff: a height store with one read-modify-write per bar.
//
// Usage: req beats carry a mode and a bar value. Mode 0 is a one millisecond tick and
// gives no result. Mode 1 is the next bar of the current frame; it gives zero or one
// rsp beat, a paint rectangle when the bar rises or an erase rectangle when it falls.
// The csr channel writes one register per beat (index and data).
//
// Flow: a bar accepted at one clock edge reads its stored height at that edge, waits in
// the update stage, and its rsp beat is registered when the stage advances. Throughput
// is one item per cycle while the divider is idle and rsp is not stalled; the height
// store takes one read and one write per cycle, and a bar that hits the entry written
// in the same edge gets the new height forwarded.
// Each csr write recomputes the bar width with a bit-serial divider; req_ready and
// csr_ready stay low after the write beat while the divider is loaded and runs.
//
// Reset: registers take their default values and every stored height reads as zero
// at once, through one valid bit per entry; no clearing pass is needed.
// Stall: a finished result waits in the rsp register while the next bar is read; when the
// update stage and the rsp register are full and rsp_ready is low, req_ready goes low.
module spectrum_bar_falloff_drawer_unit #(
   parameter int MAX_BARS = sbfd_pkg::MAX_BARS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sbfd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sbfd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sbfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbfd_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int ADDR_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int CNT_W  = sbfd_pkg::CNT_W;
   localparam int PIX_W  = sbfd_pkg::PIX_W;
   localparam int DIV_STEPS = sbfd_pkg::PIX_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Update stage contents.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  value;
      logic              fall;
      logic [PIX_W-1:0]  x;
      logic              fwd;
      logic [PIX_W-1:0]  fwd_data;
   } stage_type;

   // Configuration registers.
   logic [CNT_W-1:0]                 bar_count_ff;
   logic [PIX_W-1:0]                 screen_width_ff;
   logic [PIX_W-1:0]                 screen_height_ff;
   logic [sbfd_pkg::STEP_W-1:0]      fall_interval_ff;
   logic [sbfd_pkg::STEP_W-1:0]      fall_step_ff;
   logic [sbfd_pkg::COLOR_W-1:0]     bg_color_ff;
   logic [PIX_W-1:0]                 bar_width_ff;

   // Frame state.
   logic [sbfd_pkg::TIME_W-1:0]      now_ff;
   logic [sbfd_pkg::TIME_W-1:0]      next_fall_ff;
   logic                             fall_frame_ff;
   logic [ADDR_W-1:0]                bar_pos_ff;

   // Height store and its read port.
   logic [PIX_W-1:0]                 heights_ff [MAX_BARS];
   logic [MAX_BARS-1:0]              valid_ff;
   logic [PIX_W-1:0]                 rd_data_ff;
   logic                             rd_valid_ff;

   // Pipeline registers.
   logic                             s1_valid_ff;
   stage_type                        s1_ff;
   stage_type                        s1_in;
   logic                             rsp_valid_ff;
   sbfd_pkg::rsp_type                rsp_data_ff;
   sbfd_pkg::rsp_type                rsp_in;

   // Divider state.
   logic                             div_load_ff;
   logic                             div_busy_ff;
   logic [DIV_CNT_W-1:0]             div_cnt_ff;
   logic [CNT_W-1:0]                 div_rem_ff;
   logic [PIX_W-1:0]                 div_quo_ff;
   logic [CNT_W:0]                   div_shift;
   logic                             div_fit;
   logic [CNT_W-1:0]                 div_rem_in;
   logic [PIX_W-1:0]                 div_quo_in;

   // Handshake and stage-zero logic.
   logic                             req_fire;
   logic                             csr_fire;
   logic                             bar_fire;
   logic                             s1_advance;
   logic [CNT_W-1:0]                 eff_count;
   logic [ADDR_W-1:0]                pos_cur;
   logic [ADDR_W-1:0]                pos_in;
   logic [CNT_W-1:0]                 pos_plus;
   logic                             frame_start;
   logic                             fall_now;
   logic [ADDR_W+PIX_W-1:0]          x_prod;
   logic [PIX_W-1:0]                 value_clamp;

   // Update-stage logic.
   logic [PIX_W-1:0]                 cur_h;
   logic [PIX_W-1:0]                 step_ext;
   logic [PIX_W-1:0]                 diff;
   logic [PIX_W-1:0]                 drop;
   logic [PIX_W-1:0]                 fall_h;
   logic                             do_paint;
   logic                             do_fall;
   logic                             wr_en;
   logic [PIX_W-1:0]                 wr_data;

   // Handshakes.
   assign csr_ready  = !div_load_ff && !div_busy_ff;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !div_load_ff && !div_busy_ff && (!s1_valid_ff || s1_advance);
   assign req_fire   = req_valid && req_ready;
   assign csr_fire   = csr_valid && csr_ready;
   assign bar_fire   = req_fire && (req_data.mode == sbfd_pkg::MODE_BAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Effective bar count, clamped to one through the store depth.
   always_comb begin
      if (bar_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (bar_count_ff > CNT_W'(MAX_BARS)) begin
         eff_count = CNT_W'(MAX_BARS);
      end else begin
         eff_count = bar_count_ff;
      end
   end

   // Bar position, fall decision, clamp, rectangle x and write forwarding for the incoming bar.
   always_comb begin
      pos_cur     = (CNT_W'(bar_pos_ff) >= eff_count) ? '0 : bar_pos_ff;
      pos_plus    = CNT_W'(pos_cur) + CNT_W'(1);
      pos_in      = (pos_plus >= eff_count) ? '0 : pos_plus[ADDR_W-1:0];
      frame_start = (pos_cur == '0);
      fall_now    = frame_start ? (next_fall_ff < now_ff) : fall_frame_ff;
      x_prod      = (ADDR_W+PIX_W)'(pos_cur) * (ADDR_W+PIX_W)'(bar_width_ff);
      if (req_data.bar_value > sbfd_pkg::VALUE_W'(screen_height_ff)) begin
         value_clamp = screen_height_ff;
      end else begin
         value_clamp = req_data.bar_value[PIX_W-1:0];
      end
      s1_in.addr     = pos_cur;
      s1_in.value    = value_clamp;
      s1_in.fall     = fall_now;
      s1_in.x        = x_prod[PIX_W-1:0];
      s1_in.fwd      = wr_en && (wr_addr_match());
      s1_in.fwd_data = wr_data;
   end

   function automatic logic wr_addr_match();
      return s1_ff.addr == pos_cur;
   endfunction

   // Height update: paint on a rise, decay on a fall frame.
   always_comb begin
      if (s1_ff.fwd) begin
         cur_h = s1_ff.fwd_data;
      end else begin
         cur_h = rd_valid_ff ? rd_data_ff : '0;
      end
      step_ext = PIX_W'(fall_step_ff);
      diff     = cur_h - s1_ff.value;
      drop     = (diff > step_ext) ? step_ext : diff;
      fall_h   = (cur_h <= step_ext) ? '0 : (cur_h - drop);
      do_paint = cur_h < s1_ff.value;
      do_fall  = !do_paint && s1_ff.fall && (cur_h != '0) && (cur_h != s1_ff.value);
      wr_en    = s1_advance && (do_paint || do_fall);
      wr_data  = do_paint ? s1_ff.value : fall_h;

      rsp_in.rect_x = s1_ff.x;
      rsp_in.rect_w = bar_width_ff;
      if (do_paint) begin
         rsp_in.rect_y     = screen_height_ff - s1_ff.value;
         rsp_in.rect_h     = s1_ff.value;
         rsp_in.fill_color = sbfd_pkg::PAINT_COLOR;
         rsp_in.is_erase   = 1'b0;
      end else begin
         rsp_in.rect_y     = '0;
         rsp_in.rect_h     = (screen_height_ff > fall_h) ? (screen_height_ff - fall_h) : '0;
         rsp_in.fill_color = bg_color_ff;
         rsp_in.is_erase   = 1'b1;
      end
   end

   // Divider step: one quotient bit per cycle while the divider is busy.
   always_comb begin
      div_shift = {div_rem_ff, div_quo_ff[PIX_W-1]};
      div_fit   = div_shift >= (CNT_W+1)'(eff_count);
      if (div_fit) begin
         div_rem_in = CNT_W'(div_shift - (CNT_W+1)'(eff_count));
      end else begin
         div_rem_in = div_shift[CNT_W-1:0];
      end
      div_quo_in = {div_quo_ff[PIX_W-2:0], div_fit};
   end

   // Height store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heights_ff[s1_ff.addr] <= wr_data;
      end
      if (bar_fire) begin
         rd_data_ff <= heights_ff[pos_cur];
      end
   end

   // Control state, configuration, frame state and pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_count_ff     <= sbfd_pkg::BAR_COUNT_RST;
         screen_width_ff  <= sbfd_pkg::SCREEN_WIDTH_RST;
         screen_height_ff <= sbfd_pkg::SCREEN_HEIGHT_RST;
         fall_interval_ff <= sbfd_pkg::FALL_INTERVAL_RST;
         fall_step_ff     <= sbfd_pkg::FALL_STEP_RST;
         bg_color_ff      <= sbfd_pkg::BG_COLOR_RST;
         bar_width_ff     <= sbfd_pkg::BAR_WIDTH_RST;
         now_ff           <= '0;
         next_fall_ff     <= '0;
         fall_frame_ff    <= 1'b0;
         bar_pos_ff       <= '0;
         valid_ff         <= '0;
         rd_valid_ff      <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         div_load_ff      <= 1'b0;
         div_busy_ff      <= 1'b0;
         div_cnt_ff       <= '0;
      end else begin
         // Register writes; any write restarts the width division.
         if (csr_fire) begin
            unique case (csr_index)
               sbfd_pkg::CSR_BAR_COUNT:     bar_count_ff     <= csr_data[CNT_W-1:0];
               sbfd_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[PIX_W-1:0];
               sbfd_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[PIX_W-1:0];
               sbfd_pkg::CSR_FALL_INTERVAL: fall_interval_ff <= csr_data[7:0];
               sbfd_pkg::CSR_FALL_STEP:     fall_step_ff     <= csr_data[7:0];
               sbfd_pkg::CSR_BG_COLOR:      bg_color_ff      <= csr_data;
               default: ;
            endcase
         end
         div_load_ff <= csr_fire;

         // Bar width = screen width / effective bar count.
         if (div_load_ff) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
            div_rem_ff  <= '0;
            div_quo_ff  <= screen_width_ff;
         end else if (div_busy_ff) begin
            div_rem_ff <= div_rem_in;
            div_quo_ff <= div_quo_in;
            div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               div_busy_ff  <= 1'b0;
               bar_width_ff <= div_quo_in;
            end
         end

         // Ticks and frame bookkeeping.
         if (req_fire && (req_data.mode == sbfd_pkg::MODE_TICK)) begin
            now_ff <= now_ff + sbfd_pkg::TIME_W'(1);
         end
         if (bar_fire) begin
            bar_pos_ff  <= pos_in;
            rd_valid_ff <= valid_ff[pos_cur];
            s1_ff       <= s1_in;
            if (frame_start) begin
               fall_frame_ff <= fall_now;
               if (fall_now) begin
                  next_fall_ff <= now_ff + sbfd_pkg::TIME_W'(fall_interval_ff);
               end
            end
         end

         // Entry valid bits.
         if (wr_en) begin
            valid_ff[s1_ff.addr] <= 1'b1;
         end

         // Update stage occupancy.
         if (bar_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end

         // Result register.
         if (s1_advance) begin
            rsp_valid_ff <= do_paint || do_fall;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            rsp_data_ff <= rsp_in;
         end
      end
   end

   // A configuration beat blocks the next req beat while the width is recomputed.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("req accepted during bar width division");

   // Every height write produces a pending result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff)
      else $error("height written without a result beat");

   // A stalled update stage keeps its bar.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_ff.addr))
      else $error("update stage lost its bar while stalled");

   // The divider never runs with an empty step count.
   assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> div_cnt_ff != '0)
      else $error("divider busy with no steps left");

endmodule

/* sim/tb_spectrum_bar_falloff_drawer_unit.sv */
// Self-checking testbench for the spectrum bar falloff drawer: directed plan, random phases.
module tb_spectrum_bar_falloff_drawer_unit;
   import sbfd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 550;
   // Cycles to let an in-flight bar settle before a register write or the end of the run.
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 10;

   // How a directed row is checked.
   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_RECT} check_kind_e;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      req_type               beat;
      check_kind_e           check;
      rsp_type               rect;
   } plan_row_t;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Shadow registers and drawing state of the predictor.
   logic [CNT_W-1:0]   cfg_bar_count;
   logic [PIX_W-1:0]   cfg_screen_width;
   logic [PIX_W-1:0]   cfg_screen_height;
   logic [STEP_W-1:0]  cfg_fall_interval;
   logic [STEP_W-1:0]  cfg_fall_step;
   logic [COLOR_W-1:0] cfg_bg_color;
   logic [PIX_W-1:0]   bar_width_r;
   logic [PIX_W-1:0]   heights [MAX_BARS_DEF];
   logic [TIME_W-1:0]  now_ms;
   logic [TIME_W-1:0]  next_fall_ms;
   logic               fall_frame;
   int unsigned        bar_pos;

   rsp_type   rect_queue [$];
   plan_row_t plan [$];
   rsp_type   want;

   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int rsp_stall = 0;
   int errors = 0;
   int cycle_count = 0;
   int beats_sent = 0;
   int ticks_sent = 0;
   int paints_seen = 0;
   int erases_seen = 0;
   int csr_writes = 0;
   int phases = 0;

   spectrum_bar_falloff_drawer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bar count as the block uses it: zero acts as one, large counts clamp to the store.
   function automatic int unsigned active_bars();
      if (cfg_bar_count == '0) return 1;
      if (cfg_bar_count > MAX_BARS_DEF) return MAX_BARS_DEF;
      return cfg_bar_count;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      bit known;
      known = 1'b1;
      case (idx)
         CSR_BAR_COUNT:     cfg_bar_count     = val[CNT_W-1:0];
         CSR_SCREEN_WIDTH:  cfg_screen_width  = val[PIX_W-1:0];
         CSR_SCREEN_HEIGHT: cfg_screen_height = val[PIX_W-1:0];
         CSR_FALL_INTERVAL: cfg_fall_interval = val[STEP_W-1:0];
         CSR_FALL_STEP:     cfg_fall_step     = val[STEP_W-1:0];
         CSR_BG_COLOR:      cfg_bg_color      = val[COLOR_W-1:0];
         default:           known = 1'b0;
      endcase
      // Any write to a real register recomputes the bar width.
      if (known) bar_width_r = PIX_W'(cfg_screen_width / active_bars());
   endfunction

   // Works out the rectangle that one accepted beat draws; returns 1 when there is one.
   function automatic bit predict_rect(input req_type beat, output rsp_type rect);
      int unsigned       count;
      int unsigned       b;
      logic [VALUE_W-1:0] clamped;
      logic [PIX_W-1:0]  h;
      logic [PIX_W-1:0]  v;
      logic [PIX_W-1:0]  drop;
      bit                hit;
      rect = '0;
      hit = 1'b0;
      if (beat.mode == MODE_TICK) begin
         now_ms = now_ms + 1'b1;
         return 1'b0;
      end
      count = active_bars();
      // A lowered count can leave the position past the end; that starts a new frame.
      if (bar_pos >= count) bar_pos = 0;
      b = bar_pos;
      if (b == 0) begin
         fall_frame = next_fall_ms < now_ms;
         if (fall_frame) next_fall_ms = now_ms + TIME_W'(cfg_fall_interval);
      end
      clamped = beat.bar_value;
      if (clamped > cfg_screen_height) clamped = cfg_screen_height;
      v = clamped[PIX_W-1:0];
      h = heights[b];
      rect.rect_x = PIX_W'(b * bar_width_r);
      rect.rect_w = bar_width_r;
      if (h < v) begin
         // Rising bar: paint up to the new height.
         heights[b] = v;
         rect.rect_y = cfg_screen_height - v;
         rect.rect_h = v;
         rect.fill_color = PAINT_COLOR;
         rect.is_erase = 1'b0;
         hit = 1'b1;
      end else if (fall_frame && h != '0 && h != v) begin
         // Falling bar: drop by at most the step, then erase everything above it.
         if (h <= cfg_fall_step) begin
            h = '0;
         end else begin
            drop = h - v;
            if (drop > cfg_fall_step) drop = cfg_fall_step;
            h = h - drop;
         end
         heights[b] = h;
         rect.rect_y = '0;
         rect.rect_h = (cfg_screen_height > h) ? cfg_screen_height - h : '0;
         rect.fill_color = cfg_bg_color;
         rect.is_erase = 1'b1;
         hit = 1'b1;
      end
      bar_pos = b + 1;
      if (bar_pos >= count) bar_pos = 0;
      return hit;
   endfunction

   function automatic plan_row_t csr_row(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] val);
      plan_row_t row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   function automatic plan_row_t bar_row(input logic mode, input logic [VALUE_W-1:0] value);
      plan_row_t row;
      row = '0;
      row.beat.mode = mode;
      row.beat.bar_value = value;
      row.check = EXP_PREDICT;
      return row;
   endfunction

   function automatic plan_row_t quiet_row(input logic [VALUE_W-1:0] value);
      plan_row_t row;
      row = bar_row(MODE_BAR, value);
      row.check = EXP_NONE;
      return row;
   endfunction

   function automatic plan_row_t rect_row(input logic [VALUE_W-1:0] value,
                                          input logic [PIX_W-1:0] x, y, w, h,
                                          input logic [COLOR_W-1:0] color,
                                          input logic erase);
      plan_row_t row;
      row = bar_row(MODE_BAR, value);
      row.check = EXP_RECT;
      row.rect.rect_x = x;
      row.rect.rect_y = y;
      row.rect.rect_w = w;
      row.rect.rect_h = h;
      row.rect.fill_color = color;
      row.rect.is_erase = erase;
      return row;
   endfunction

   // Idle length: mostly short, now and then long.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_csr_value(input logic [CSR_IDX_W-1:0] idx);
      int r;
      r = $urandom_range(0, 9);
      case (idx)
         CSR_BAR_COUNT: begin
            if (r < 3) return $urandom_range(1, 4);
            if (r < 6) return $urandom_range(5, 32);
            if (r == 6) return $urandom_range(33, MAX_BARS_DEF);
            if (r == 7) return $urandom_range(0, 1) ? 16'd0 : 16'h01FF;
            if (r == 8) return $urandom;
            return MAX_BARS_DEF;
         end
         CSR_SCREEN_WIDTH: begin
            if (r < 7) return $urandom_range(1, 4095);
            if (r == 7) return 16'd0;
            if (r == 8) return 16'd4095;
            return $urandom;
         end
         CSR_SCREEN_HEIGHT: begin
            if (r < 7) return $urandom_range(1, 300);
            if (r == 7) return 16'd0;
            if (r == 8) return 16'd4095;
            return $urandom_range(301, 4095);
         end
         CSR_FALL_INTERVAL: begin
            if (r < 7) return $urandom_range(0, 6);
            if (r == 7) return 16'd255;
            return $urandom;
         end
         CSR_FALL_STEP: begin
            if (r < 6) return $urandom_range(0, 20);
            if (r == 6) return 16'd0;
            if (r == 7) return 16'd255;
            return $urandom;
         end
         CSR_BG_COLOR: begin
            if (r == 0) return 16'd0;
            if (r == 1) return 16'hFFFF;
            return $urandom;
         end
         default: return $urandom;
      endcase
   endfunction

   // Random beat; a falloff phase sends low values and frequent ticks so that bars decay.
   function automatic req_type random_beat(input bit falloff);
      req_type     beat;
      int unsigned sh;
      int          r;
      sh = cfg_screen_height;
      beat.bar_value = $urandom;
      beat.mode = ($urandom_range(0, 99) < (falloff ? 40 : 15)) ? MODE_TICK : MODE_BAR;
      if (beat.mode == MODE_BAR) begin
         r = $urandom_range(0, 99);
         if (r < 12) beat.bar_value = $urandom;
         else if (r < 20) beat.bar_value = '0;
         else if (r < 26) beat.bar_value = sh;
         else if (r < 30) beat.bar_value = '1;
         else if (falloff) beat.bar_value = $urandom_range(0, sh / 4);
         else beat.bar_value = $urandom_range(0, sh + sh / 8 + 1);
      end
      return beat;
   endfunction

   // Drives one request beat and records what it should draw once it is accepted.
   task automatic send_beat(input req_type beat, input check_kind_e check, input rsp_type typed);
      rsp_type rect;
      bit      hit;
      int      gap;
      @(negedge clock);
      gap = (req_quiet || $urandom_range(0, 99) < 55) ? 0 : idle_span();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      hit = predict_rect(beat, rect);
      beats_sent++;
      if (beat.mode == MODE_TICK) ticks_sent++;
      case (check)
         EXP_PREDICT: if (hit) rect_queue.push_back(rect);
         EXP_RECT:    rect_queue.push_back(typed);
         default:     ;
      endcase
   endtask

   // Register writes happen only with the block idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      req_valid <= 1'b0;
      while (rect_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] got_val);
      if (got_val !== exp_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      end
   endtask

   // Result side: random stalls, with quiet stretches.
   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_quiet && $urandom_range(0, 99) < 30) rsp_stall = idle_span();
      end
   end

   // Each result beat is checked against the oldest expected rectangle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rect_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected rectangle, expected none, got %h", $time, rsp_data);
         end else begin
            want = rect_queue.pop_front();
            check_field("rect_x", want.rect_x, rsp_data.rect_x);
            check_field("rect_y", want.rect_y, rsp_data.rect_y);
            check_field("rect_w", want.rect_w, rsp_data.rect_w);
            check_field("rect_h", want.rect_h, rsp_data.rect_h);
            check_field("fill_color", want.fill_color, rsp_data.fill_color);
            check_field("is_erase", want.is_erase, rsp_data.is_erase);
            if (want.is_erase) erases_seen++;
            else paints_seen++;
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d rectangles outstanding",
               cycle_count, rect_queue.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int          random_end;
      int          n_writes;
      int          n_beats;
      bit          falloff;
      logic [CSR_IDX_W-1:0] idx;

      // Predictor state after reset.
      cfg_bar_count = BAR_COUNT_RST;
      cfg_screen_width = SCREEN_WIDTH_RST;
      cfg_screen_height = SCREEN_HEIGHT_RST;
      cfg_fall_interval = FALL_INTERVAL_RST;
      cfg_fall_step = FALL_STEP_RST;
      cfg_bg_color = BG_COLOR_RST;
      bar_width_r = BAR_WIDTH_RST;
      foreach (heights[i]) heights[i] = '0;
      now_ms = '0;
      next_fall_ms = '0;
      fall_frame = 1'b0;
      bar_pos = 0;

      // Directed plan. Defaults first: 32 bars of width 10 on a 240 pixel screen.
      plan.push_back(quiet_row(32'd0));
      plan.push_back(rect_row(32'hFFFF_FFFF, 12'd10, 12'd0, 12'd10, 12'd240, PAINT_COLOR, 1'b0));
      plan.push_back(rect_row(32'd100, 12'd20, 12'd140, 12'd10, 12'd100, PAINT_COLOR, 1'b0));
      // Count lowered to the current position mid-frame; from here any frame after a tick falls.
      plan.push_back(csr_row(CSR_BAR_COUNT, 16'd3));
      plan.push_back(csr_row(CSR_FALL_INTERVAL, 16'd0));
      plan.push_back(bar_row(MODE_TICK, 32'd0));
      plan.push_back(quiet_row(32'd0));
      plan.push_back(bar_row(MODE_BAR, 32'd0));
      plan.push_back(bar_row(MODE_BAR, 32'd98));
      // Largest step drops a bar to zero; erase uses a white background.
      plan.push_back(csr_row(CSR_FALL_STEP, 16'd255));
      plan.push_back(csr_row(CSR_BG_COLOR, 16'hFFFF));
      plan.push_back(bar_row(MODE_TICK, 32'hFFFF_FFFF));
      plan.push_back(bar_row(MODE_BAR, 32'd5));
      plan.push_back(rect_row(32'd0, 12'd106, 12'd0, 12'd106, 12'd240, 16'hFFFF, 1'b1));
      plan.push_back(quiet_row(32'd98));
      // Screen lowered under a stored bar: the erase height saturates at zero.
      plan.push_back(csr_row(CSR_SCREEN_HEIGHT, 16'd50));
      plan.push_back(csr_row(CSR_FALL_STEP, 16'd0));
      plan.push_back(bar_row(MODE_TICK, 32'd0));
      plan.push_back(bar_row(MODE_BAR, 32'd7));
      plan.push_back(quiet_row(32'd0));
      plan.push_back(rect_row(32'd10, 12'd212, 12'd0, 12'd106, 12'd0, 16'hFFFF, 1'b1));
      // Zero screen width and a zero count give zero-width rectangles.
      plan.push_back(csr_row(CSR_SCREEN_WIDTH, 16'd0));
      plan.push_back(csr_row(CSR_BAR_COUNT, 16'd0));
      plan.push_back(rect_row(32'hFFFF_FFFF, 12'd0, 12'd0, 12'd0, 12'd50, PAINT_COLOR, 1'b0));
      // Count above the store clamps to its size; full-size screen.
      plan.push_back(csr_row(CSR_BAR_COUNT, 16'h01FF));
      plan.push_back(csr_row(CSR_SCREEN_WIDTH, 16'hFFFF));
      plan.push_back(csr_row(CSR_SCREEN_HEIGHT, 16'd4095));
      plan.push_back(bar_row(MODE_BAR, 32'd4095));
      plan.push_back(bar_row(MODE_BAR, 32'd1));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_csr(plan[i].csr_idx, plan[i].csr_val);
         else send_beat(plan[i].beat, plan[i].check, plan[i].rect);
      end

      // Random phases: a few register writes, then a run of beats under one setting.
      random_end = beats_sent + RANDOM_BEATS;
      while (beats_sent < random_end) begin
         phases++;
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         n_writes = $urandom_range(1, 3);
         repeat (n_writes) begin
            if ($urandom_range(0, 19) == 0)
               idx = CSR_BG_COLOR + 1 + $urandom_range(0, 1);
            else
               idx = $urandom_range(CSR_BAR_COUNT, CSR_BG_COLOR);
            write_csr(idx, pick_csr_value(idx));
         end
         falloff = ($urandom_range(0, 2) == 0);
         n_beats = $urandom_range(15, 60);
         repeat (n_beats) send_beat(random_beat(falloff), EXP_PREDICT, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (rect_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rect_queue.size() != 0) begin
         errors++;
         $display("%0t: %0d expected rectangles never arrived", $time, rect_queue.size());
      end

      $display("Sent %0d request beats (%0d ticks) over %0d random phases, %0d register writes.",
               beats_sent, ticks_sent, phases, csr_writes);
      $display("Checked %0d paint and %0d erase rectangles, %0d errors.",
               paints_seen, erases_seen, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/sbfd_pkg.sv
hdl/spectrum_bar_falloff_drawer_unit.sv
sim/tb_spectrum_bar_falloff_drawer_unit.sv
